// ----- hw/rtl/ssc_pkg.sv -----
// Package for the sorted sparse coefficient store: sizes, action and status codes,
// the entry and result types and the list address helper.
// No dependencies; ssc_ctrl and the top-level store use it.
package ssc_pkg;

    // Store geometry.
    localparam int MAX_ORDER         = 8;
    localparam int ENTRIES_PER_ORDER = 64;
    localparam int STORE_DEPTH       = MAX_ORDER * ENTRIES_PER_ORDER;

    // Field widths fixed by the interface.
    localparam int ACTION_W = 2;
    localparam int ORDER_W  = 4;
    localparam int KEY_W    = 32;
    localparam int COEF_W   = 64;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 4;

    // Derived widths.
    localparam int LIST_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CNT_W  = $clog2(ENTRIES_PER_ORDER + 1);
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int LIM_W  = ORDER_W + 1;

    localparam logic [ADDR_W-1:0] ENTRIES_A = ADDR_W'(ENTRIES_PER_ORDER);
    localparam logic [CNT_W-1:0]  ENTRIES_C = CNT_W'(ENTRIES_PER_ORDER);
    localparam logic [LIM_W-1:0]  MAX_ORDER_L = LIM_W'(MAX_ORDER);

    // Reset value of the orders_in_use register.
    localparam logic [CFG_W-1:0] ORDERS_RESET = 4'd2;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_GET   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SET   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

    // One stored list entry.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [COEF_W-1:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // One result word as handed from the sequencer to the output register.
    typedef struct packed {
        logic [COEF_W-1:0]   coef;
        logic                found;
        logic [STATUS_W-1:0] status;
    } result_t;

    // Memory address of a position within a list.
    function automatic logic [ADDR_W-1:0] entry_addr(input logic [LIST_W-1:0] lst,
                                                     input logic [CNT_W-1:0]  pos);
        entry_addr = ADDR_W'(lst) * ENTRIES_A + ADDR_W'(pos);
    endfunction

endpackage

// ----- hw/rtl/ssc_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module ssc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/ssc_ctrl.sv -----
// Sequencer of the coefficient store: binary search, overwrite and shifting insert
// over the entry memory, plus the real part and the per-list fill counts.
// Depends on ssc_pkg.
module ssc_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    // Incoming word.
    input  logic                            start,
    output logic                            idle,
    input  logic [ssc_pkg::ACTION_W-1:0]    action,
    input  logic [ssc_pkg::ORDER_W-1:0]     order,
    input  logic [ssc_pkg::KEY_W-1:0]       direction_index,
    input  logic [ssc_pkg::COEF_W-1:0]      coefficient_in,
    input  logic [ssc_pkg::CFG_W-1:0]       orders_in_use,
    // Finished result.
    output logic                            res_valid,
    input  logic                            res_take,
    output ssc_pkg::result_t                res,
    // Entry memory.
    output logic                            mem_we,
    output logic [ssc_pkg::ADDR_W-1:0]      mem_waddr,
    output ssc_pkg::entry_t                 mem_wdata,
    output logic                            mem_re,
    output logic [ssc_pkg::ADDR_W-1:0]      mem_raddr,
    input  ssc_pkg::entry_t                 mem_rdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_SCMP = 3'd2;
    localparam logic [2:0] S_PCHK = 3'd3;
    localparam logic [2:0] S_SHRD = 3'd4;
    localparam logic [2:0] S_SHWR = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam int CW = ssc_pkg::CNT_W;

    logic [2:0] state_reg, state_next;
    logic [CW-1:0] counts_reg [ssc_pkg::MAX_ORDER];
    logic [CW-1:0] counts_next [ssc_pkg::MAX_ORDER];
    logic [ssc_pkg::COEF_W-1:0] real_reg, real_next;

    logic [ssc_pkg::ACTION_W-1:0] act_reg, act_next;
    logic [ssc_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [ssc_pkg::COEF_W-1:0]   val_reg, val_next;
    logic [ssc_pkg::LIST_W-1:0]   lst_reg, lst_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] k_reg, k_next;
    ssc_pkg::result_t res_reg, res_next;

    logic [CW-1:0] mid;
    logic [ssc_pkg::LIM_W-1:0] limit;
    logic [ssc_pkg::ORDER_W-1:0] order_m1;
    logic [ssc_pkg::LIST_W-1:0] lst_in;
    logic do_resolve;
    logic hit_now;

    // Midpoint of the search window, active list limit and the list slot of an order.
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign limit    = ({1'b0, orders_in_use} < ssc_pkg::MAX_ORDER_L)
                      ? {1'b0, orders_in_use} : ssc_pkg::MAX_ORDER_L;
    assign order_m1 = order - ssc_pkg::ORDER_W'(1);
    assign lst_in   = order_m1[ssc_pkg::LIST_W-1:0];

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // Next-state and memory access logic.
    always_comb
    begin
        state_next  = state_reg;
        counts_next = counts_reg;
        real_next   = real_reg;
        act_next    = act_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        lst_next    = lst_reg;
        n_next      = n_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        k_next      = k_reg;
        res_next    = res_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        do_resolve  = 1'b0;
        hit_now     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next   = action;
                    key_next   = direction_index;
                    val_next   = coefficient_in;
                    res_next   = '0;
                    state_next = S_DONE;
                    unique case (action) inside
                        ssc_pkg::ACT_CLEAR:
                        begin
                            real_next = coefficient_in;
                            for (int i = 0; i < ssc_pkg::MAX_ORDER; i++)
                            begin
                                counts_next[i] = '0;
                            end
                        end
                        ssc_pkg::ACT_GET, ssc_pkg::ACT_SET:
                        begin
                            if (order == '0)
                            begin
                                if (action == ssc_pkg::ACT_GET)
                                begin
                                    res_next.coef = real_reg;
                                end
                                else
                                begin
                                    real_next = coefficient_in;
                                end
                            end
                            else if ({1'b0, order} > limit)
                            begin
                                res_next.status = ssc_pkg::ST_IGNORED;
                            end
                            else
                            begin
                                lst_next   = lst_in;
                                n_next     = counts_reg[lst_in];
                                lo_next    = '0;
                                hi_next    = counts_reg[lst_in];
                                state_next = S_SRCH;
                            end
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end

            // Issue the probe of the midpoint, or of the final position.
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ssc_pkg::entry_addr(lst_reg, mid);
                    state_next = S_SCMP;
                end
                else if (lo_reg < n_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ssc_pkg::entry_addr(lst_reg, lo_reg);
                    state_next = S_PCHK;
                end
                else
                begin
                    do_resolve = 1'b1;
                    hit_now    = 1'b0;
                end
            end

            // Narrow the window with the key read at the midpoint.
            S_SCMP:
            begin
                if (mem_rdata.key < key_reg)
                begin
                    lo_next = mid + CW'(1);
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = S_SRCH;
            end

            S_PCHK:
            begin
                do_resolve = 1'b1;
                hit_now    = (mem_rdata.key == key_reg);
            end

            // Move one entry up per read (S_SHRD) and write-back (S_SHWR), then place the new one.
            S_SHRD:
            begin
                if (k_reg > lo_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ssc_pkg::entry_addr(lst_reg, k_reg - CW'(1));
                    state_next = S_SHWR;
                end
                else
                begin
                    mem_we               = 1'b1;
                    mem_waddr            = ssc_pkg::entry_addr(lst_reg, lo_reg);
                    mem_wdata.key        = key_reg;
                    mem_wdata.value      = val_reg;
                    counts_next[lst_reg] = n_reg + CW'(1);
                    state_next           = S_DONE;
                end
            end

            S_SHWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ssc_pkg::entry_addr(lst_reg, k_reg);
                mem_wdata  = mem_rdata;
                k_next     = k_reg - CW'(1);
                state_next = S_SHRD;
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The search has settled: act on the position and the hit flag.
        if (do_resolve)
        begin
            res_next.found = hit_now;
            state_next     = S_DONE;
            if (act_reg == ssc_pkg::ACT_GET)
            begin
                if (hit_now)
                begin
                    res_next.coef = mem_rdata.value;
                end
            end
            else if (hit_now)
            begin
                mem_we          = 1'b1;
                mem_waddr       = ssc_pkg::entry_addr(lst_reg, lo_reg);
                mem_wdata.key   = key_reg;
                mem_wdata.value = val_reg;
            end
            else if (n_reg >= ssc_pkg::ENTRIES_C)
            begin
                res_next.status = ssc_pkg::ST_FULL;
            end
            else
            begin
                k_next     = n_reg;
                state_next = S_SHRD;
            end
        end
    end

    // Control state, fill counts and real part.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            real_reg  <= '0;
            for (int i = 0; i < ssc_pkg::MAX_ORDER; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            real_reg   <= real_next;
            counts_reg <= counts_next;
        end
    end

    // Working registers of the current word.
    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        key_reg <= key_next;
        val_reg <= val_next;
        lst_reg <= lst_next;
        n_reg   <= n_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        k_reg   <= k_next;
        res_reg <= res_next;
    end

endmodule

// ----- hw/rtl/sorted_sparse_coefficient_store.sv -----
// Sorted sparse coefficient store: one word at a time. Real-part access, clear and
// ignored orders go from acceptance through the done state to the output register;
// a list lookup runs a binary search over the n entries of the list, then a final probe;
// an insert adds a shift, one read and one write-back per moved entry, then the write.
// Reset clears the real part and the fill counts and sets orders_in_use to 2 at once;
// the entry memory is not cleared, so no clearing pass runs after reset.
module sorted_sparse_coefficient_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ssc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ssc_pkg::ACTION_W-1:0]  action,
    input  logic [ssc_pkg::ORDER_W-1:0]   order,
    input  logic [ssc_pkg::KEY_W-1:0]     direction_index,
    input  logic [ssc_pkg::COEF_W-1:0]    coefficient_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ssc_pkg::COEF_W-1:0]    coefficient_out,
    output logic                          found,
    output logic [ssc_pkg::STATUS_W-1:0]  status
);

    logic [ssc_pkg::CFG_W-1:0] orders_reg;
    logic out_valid_reg;
    ssc_pkg::result_t out_reg;

    logic idle;
    logic res_valid;
    logic res_take;
    ssc_pkg::result_t res;
    logic mem_we;
    logic mem_re;
    logic [ssc_pkg::ADDR_W-1:0] mem_waddr;
    logic [ssc_pkg::ADDR_W-1:0] mem_raddr;
    ssc_pkg::entry_t mem_wdata;
    ssc_pkg::entry_t mem_rdata;

    assign cfg_ready = 1'b1;
    assign in_ready  = idle;
    assign res_take  = res_valid && (!out_valid_reg || out_ready);

    assign out_valid       = out_valid_reg;
    assign coefficient_out = out_reg.coef;
    assign found           = out_reg.found;
    assign status          = out_reg.status;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orders_reg <= ssc_pkg::ORDERS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            orders_reg <= cfg_data;
        end
    end

    // Output register: holds a finished word until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    ssc_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (in_valid && in_ready),
        .idle            (idle),
        .action          (action),
        .order           (order),
        .direction_index (direction_index),
        .coefficient_in  (coefficient_in),
        .orders_in_use   (orders_reg),
        .res_valid       (res_valid),
        .res_take        (res_take),
        .res             (res),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_re          (mem_re),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata)
    );

    ssc_ram #(
        .DATA_W (ssc_pkg::ENTRY_W),
        .DEPTH  (ssc_pkg::STORE_DEPTH),
        .ADDR_W (ssc_pkg::ADDR_W)
    ) u_entries (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
